// File: rtl/ace_pkg.sv
// shared types and constants for the binary arithmetic encoder
// used by ace_step, arithmetic_coder_encoder and the bench, no dependencies

package ace_pkg;

  localparam int CUM_LOW_W  = 16;
  localparam int CUM_TOP_W  = 17;
  localparam int COUNT_W    = 16;
  localparam int MAX_SHIFTS = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [CUM_LOW_W-1:0] cum_low;
    logic [CUM_TOP_W-1:0] cum_top;
  } in_item_t;

  typedef struct packed {
    logic               first_bit;
    logic [COUNT_W-1:0] follow_count;
    logic               last;
  } out_item_t;

  // renormalization decision for one shift step
  typedef enum logic [1:0] {
    ACT_STOP,
    ACT_EMIT0,
    ACT_EMIT1,
    ACT_FOLLOW
  } step_act_e;

endpackage

// File: rtl/ace_mul.sv
// shared multiplier of the encoder, product registered
// depends on nothing but its parameters

module ace_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  logic [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/ace_step.sv
// one renormalization step of the encoder interval
// depends on ace_pkg for the step decision codes

module ace_step #(
  parameter int P = 16
) (
  input  logic [P-1:0]          lo_i,
  input  logic [P-1:0]          hi_i,
  output ace_pkg::step_act_e    act_o,
  output logic [P-1:0]          lo_o,
  output logic [P-1:0]          hi_o
);

  localparam logic [P-1:0] QTR = {2'b01, {(P-2){1'b0}}};

  logic [P-1:0] lo_s;
  logic [P-1:0] hi_s;

  always_comb begin
    act_o = ace_pkg::ACT_STOP;
    lo_s  = lo_i;
    hi_s  = hi_i;
    if (!hi_i[P-1]) begin
      act_o = ace_pkg::ACT_EMIT0;
    end else if (lo_i[P-1]) begin
      // top bit drops out in the shift, same as taking off half
      act_o = ace_pkg::ACT_EMIT1;
    end else if (lo_i[P-2] && !hi_i[P-2]) begin
      act_o = ace_pkg::ACT_FOLLOW;
      lo_s  = lo_i - QTR;
      hi_s  = hi_i - QTR;
    end
    lo_o = {lo_s[P-2:0], 1'b0};
    hi_o = {hi_s[P-2:0], 1'b1};
  end

endmodule

// File: rtl/arithmetic_coder_encoder.sv
// binary arithmetic encoder: sequencer, interval state and result registers
// depends on ace_pkg, ace_mul and ace_step
//
// usage: an encode item (op 0) carries a symbol's cumulative bounds scaled by
// 2^PRECISION; a finish item (op 1) flushes the final bit and restarts the
// coder. results are runs: a bit and the count of inverted bits after it,
// with last set on the final run an item causes. an encode item can cause
// none. both channels use valid/stall; in_stall_o is high while an item is
// being worked on, so one item is in the block at a time.
// sequence: an encode item runs the interval update through the one shared
// multiplier twice, high bound then low bound; the high bound add overlaps
// the second pass and the low bound add follows. then one renormalization
// shift (at most 16) per cycle through the shared step unit, unless a run
// waits for room, plus a step that finds no shift due or the cap reached,
// then a step that releases the last run, if any. a finish item writes its run
// into the output register once that is free; other runs pass the hold register.
// a stalled output holds its result; the sequencer waits whenever a new run
// finds the hold register full and the output register full and stalled.
// reset puts the interval at full range and clears the pending count and
// all valid flags.

module arithmetic_coder_encoder #(
  parameter int PRECISION     = 16,
  parameter int PENDING_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ace_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ace_pkg::out_item_t out_item_o
);

  localparam int P    = PRECISION;
  localparam int PW   = PENDING_WIDTH;
  localparam int CHW  = ace_pkg::CUM_TOP_W;
  localparam int MW   = P + 1 + CHW;
  localparam int CMPW = P + 18;
  localparam int KW   = $clog2(ace_pkg::MAX_SHIFTS + 1);
  localparam int CXW  = PW + ace_pkg::COUNT_W;

  localparam logic [PW-1:0]   PEND_MAX = {PW{1'b1}};
  localparam logic [CMPW-1:0] FULL_X   = CMPW'(1) << P;
  localparam logic [KW-1:0]   K_LIMIT  = KW'(ace_pkg::MAX_SHIFTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_HI,
    S_MUL_LO,
    S_ADD_LO,
    S_RENORM,
    S_FLUSH,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [P-1:0]   lo_q, lo_d;
  logic [P-1:0]   hi_q, hi_d;
  logic [PW-1:0]  pend_q, pend_d;
  logic [P:0]     range_q, range_d;
  logic [CHW-1:0] ch_q, ch_d;
  logic [CHW-1:0] cl_q, cl_d;
  logic [KW-1:0]  k_q, k_d;

  logic               hold_valid_q, hold_valid_d;
  ace_pkg::out_item_t hold_q, hold_d;
  logic               out_valid_q, out_valid_d;
  ace_pkg::out_item_t out_q, out_d;

  logic [CHW-1:0]  mul_b;
  logic [MW-1:0]   prod;
  logic [MW-1:0]   quot;
  logic [CHW-1:0]  ch_fix;
  logic [CMPW-1:0] ch_x;

  ace_pkg::step_act_e act;
  logic [P-1:0]       lo_step;
  logic [P-1:0]       hi_step;

  logic             out_free;
  logic [PW-1:0]    pend_inc;
  logic [CXW-1:0]   pend_x;
  logic [CXW-1:0]   pinc_x;
  logic [ace_pkg::COUNT_W-1:0] cnt_now;
  logic [ace_pkg::COUNT_W-1:0] cnt_inc;

  assign mul_b = (state_q == S_MUL_HI) ? ch_q : cl_q;

  ace_mul #(
    .AW(P + 1),
    .BW(CHW)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (range_q),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  ace_step #(
    .P(P)
  ) u_step (
    .lo_i (lo_q),
    .hi_i (hi_q),
    .act_o(act),
    .lo_o (lo_step),
    .hi_o (hi_step)
  );

  assign quot     = prod >> P;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pend_inc = (pend_q == PEND_MAX) ? pend_q : pend_q + PW'(1);
  assign pend_x   = CXW'(pend_q);
  assign pinc_x   = CXW'(pend_inc);
  assign cnt_now  = (pend_x > CXW'(ace_pkg::COUNT_MAX)) ? ace_pkg::COUNT_MAX
                                                        : pend_x[ace_pkg::COUNT_W-1:0];
  assign cnt_inc  = (pinc_x > CXW'(ace_pkg::COUNT_MAX)) ? ace_pkg::COUNT_MAX
                                                        : pinc_x[ace_pkg::COUNT_W-1:0];

  // empty interval widened by one, then high bound clamped to full scale
  always_comb begin
    ch_fix = in_item_i.cum_top;
    if (in_item_i.cum_top == CHW'(in_item_i.cum_low)) begin
      ch_fix = CHW'(in_item_i.cum_low) + CHW'(1);
    end
    ch_x = CMPW'(ch_fix);
    if (ch_x > FULL_X) begin
      ch_fix = FULL_X[CHW-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pend_d       = pend_q;
    range_d      = range_q;
    ch_d         = ch_q;
    cl_d         = cl_q;
    k_d          = k_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.op == ace_pkg::OP_FINISH) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_MUL_HI;
            ch_d    = ch_fix;
            cl_d    = CHW'(in_item_i.cum_low);
            range_d = {1'b0, hi_q} - {1'b0, lo_q} + (P+1)'(1);
            k_d     = '0;
          end
        end
      end
      S_MUL_HI: begin
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        // product holds range * high bound, low bound still old
        hi_d    = lo_q + quot[P-1:0] - P'(1);
        state_d = S_ADD_LO;
      end
      S_ADD_LO: begin
        lo_d    = lo_q + quot[P-1:0];
        state_d = S_RENORM;
      end
      S_RENORM: begin
        if (k_q == K_LIMIT || act == ace_pkg::ACT_STOP) begin
          state_d = S_FLUSH;
        end else if (act == ace_pkg::ACT_FOLLOW) begin
          pend_d = pend_inc;
          lo_d   = lo_step;
          hi_d   = hi_step;
          k_d    = k_q + KW'(1);
        end else if (!hold_valid_q || out_free) begin
          // previous run is not the last one, push it out
          if (hold_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = hold_q;
          end
          hold_valid_d        = 1'b1;
          hold_d.first_bit    = (act == ace_pkg::ACT_EMIT1);
          hold_d.follow_count = cnt_now;
          hold_d.last         = 1'b0;
          pend_d = '0;
          lo_d   = lo_step;
          hi_d   = hi_step;
          k_d    = k_q + KW'(1);
        end
      end
      S_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = hold_q;
          out_d.last   = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.first_bit    = (lo_q[P-1:P-2] != 2'b00);
          out_d.follow_count = cnt_inc;
          out_d.last         = 1'b1;
          lo_d    = '0;
          hi_d    = '1;
          pend_d  = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lo_q         <= '0;
      hi_q         <= '1;
      pend_q       <= '0;
      k_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      pend_q       <= pend_d;
      k_q          <= k_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q <= range_d;
    ch_q    <= ch_d;
    cl_q    <= cl_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a held run is always released before the next item is taken
  a_hold_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_valid_q)
    else $error("held run left over in idle");

  a_shift_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= K_LIMIT)
    else $error("shift count beyond cap");

  a_finish_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> (lo_q == '0 && hi_q == '1 && pend_q == '0))
    else $error("coder not restarted after finish");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> (out_valid_q && out_q.last))
    else $error("finish run missing or not marked last");

endmodule

// File: test/testbench.sv
// self-checking bench for arithmetic_coder_encoder: directed table and random
// symbol streams, checked against typed runs and an in-bench predictor
// depends on ace_pkg and the rtl of arithmetic_coder_encoder

module testbench;

  localparam int PREC        = 16;
  localparam int PEND_W      = 16;
  localparam int RAND_ITEMS  = 105;
  localparam int N_DIR       = 23;
  localparam int PREDICTED   = -1;

  localparam logic [16:0] FULL      = 17'h10000;
  localparam logic [15:0] HALF      = 16'h8000;
  localparam logic [15:0] QUARTER   = 16'h4000;
  localparam logic [15:0] THREE_QTR = 16'hC000;

  typedef struct {
    ace_pkg::in_item_t  item;
    int                 n_want;
    ace_pkg::out_item_t want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  ace_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ace_pkg::out_item_t out_item_o;

  // coder state as the predictor sees it
  logic [PREC-1:0]   coder_low    = '0;
  logic [PREC-1:0]   coder_high   = '1;
  logic [PEND_W-1:0] coder_follow = '0;

  ace_pkg::out_item_t due_runs[$];
  int                 mismatches = 0;
  bit                 idle_en    = 1'b1;
  int                 stall_left = 0;
  ace_pkg::out_item_t oldest_run;

  arithmetic_coder_encoder #(
    .PRECISION    (PREC),
    .PENDING_WIDTH(PEND_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic ace_pkg::out_item_t take_run(input logic bit_val);
    ace_pkg::out_item_t run;
    run.first_bit    = bit_val;
    run.follow_count = coder_follow;
    run.last         = 1'b0;
    coder_follow     = '0;
    return run;
  endfunction

  // runs that one input item produces, updating the coder state
  function automatic void predict_runs(input ace_pkg::in_item_t it,
                                       output ace_pkg::out_item_t runs[$]);
    logic [16:0]        span;
    logic [16:0]        hi_bound;
    logic [33:0]        prod_hi;
    logic [33:0]        prod_lo;
    logic [15:0]        lo;
    logic [15:0]        hi;
    int                 steps;
    bit                 busy;
    ace_pkg::out_item_t run;
    runs = {};
    if (it.op == ace_pkg::OP_FINISH) begin
      if (coder_follow != '1) coder_follow++;
      run = take_run((coder_low < QUARTER) ? 1'b0 : 1'b1);
      run.last = 1'b1;
      runs.push_back(run);
      coder_low    = '0;
      coder_high   = '1;
      coder_follow = '0;
      return;
    end
    span     = {1'b0, coder_high} - {1'b0, coder_low} + 17'd1;
    hi_bound = it.cum_top;
    if (hi_bound == {1'b0, it.cum_low}) hi_bound = {1'b0, it.cum_low} + 17'd1;
    if (hi_bound > FULL) hi_bound = FULL;
    prod_hi = 34'(span) * 34'(hi_bound);
    prod_lo = 34'(span) * 34'(it.cum_low);
    hi = coder_low + prod_hi[31:16] - 16'd1;
    lo = coder_low + prod_lo[31:16];
    steps = 0;
    busy  = 1'b1;
    while (busy && steps < ace_pkg::MAX_SHIFTS) begin
      if (hi < HALF) begin
        runs.push_back(take_run(1'b0));
      end else if (lo >= HALF) begin
        runs.push_back(take_run(1'b1));
        lo = lo - HALF;
        hi = hi - HALF;
      end else if (lo >= QUARTER && hi < THREE_QTR) begin
        if (coder_follow != '1) coder_follow++;
        lo = lo - QUARTER;
        hi = hi - QUARTER;
      end else begin
        busy = 1'b0;
      end
      if (busy) begin
        lo = {lo[14:0], 1'b0};
        hi = {hi[14:0], 1'b1};
        steps++;
      end
    end
    coder_low  = lo;
    coder_high = hi;
    if (runs.size() > 0) runs[runs.size()-1].last = 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input ace_pkg::out_item_t want,
                               input ace_pkg::out_item_t got);
    if (mismatches < 10)
      $display("%0t %s: expected bit %0d count %0d last %0d, got bit %0d count %0d last %0d",
               $time, what, want.first_bit, want.follow_count, want.last,
               got.first_bit, got.follow_count, got.last);
    mismatches++;
  endtask

  // n_want of PREDICTED takes the predictor's runs, 1 takes the typed run, else none
  task automatic push_item(input ace_pkg::in_item_t it, input int n_want,
                           input ace_pkg::out_item_t want);
    ace_pkg::out_item_t runs[$];
    int                 gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_runs(it, runs);
    if (n_want == PREDICTED) begin
      foreach (runs[i]) due_runs.push_back(runs[i]);
    end else if (n_want == 1) begin
      due_runs.push_back(want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_runs.size() == 0) begin
          note_mismatch("run with nothing expected", '0, out_item_o);
        end else begin
          oldest_run = due_runs.pop_front();
          if (out_item_o.first_bit !== oldest_run.first_bit ||
              out_item_o.follow_count !== oldest_run.follow_count ||
              out_item_o.last !== oldest_run.last)
            note_mismatch("run mismatch", oldest_run, out_item_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    dir_row_t          dir_tab [N_DIR];
    ace_pkg::in_item_t it;
    int                sent;
    int                msg_left;
    int                width;
    int                top;
    int                drain;
    bit                quiet;

    dir_tab = '{
      // after reset: full range, no pending bits
      '{'{ace_pkg::OP_FINISH, 16'd0,     17'd0},      1,         '{1'b0, 16'd1, 1'b1}},
      '{'{ace_pkg::OP_ENCODE, 16'd0,     17'd65536},  0,         '0},
      '{'{ace_pkg::OP_ENCODE, 16'd0,     17'd32768},  1,         '{1'b0, 16'd0, 1'b1}},
      '{'{ace_pkg::OP_ENCODE, 16'd32768, 17'd65536},  1,         '{1'b1, 16'd0, 1'b1}},
      // empty intervals at both ends run into the shift cap
      '{'{ace_pkg::OP_ENCODE, 16'd0,     17'd0},      PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd65535, 17'd65535},  PREDICTED, '0},
      '{'{ace_pkg::OP_FINISH, 16'd0,     17'd0},      PREDICTED, '0},
      // straddles the middle: follow bits only; then finishes around a no-shift encode
      '{'{ace_pkg::OP_ENCODE, 16'd32767, 17'd32769},  PREDICTED, '0},
      '{'{ace_pkg::OP_FINISH, 16'd0,     17'd0},      PREDICTED, '0},
      '{'{ace_pkg::OP_FINISH, 16'd65535, 17'd131071}, 1,         '{1'b0, 16'd1, 1'b1}},
      '{'{ace_pkg::OP_ENCODE, 16'd16384, 17'd65536},  0,         '0},
      '{'{ace_pkg::OP_FINISH, 16'd0,     17'd0},      1,         '{1'b1, 16'd1, 1'b1}},
      // oversized, inverted, empty and ordinary bounds
      '{'{ace_pkg::OP_ENCODE, 16'd100,   17'd131071}, PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd65535, 17'd0},      PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd40000, 17'd20000},  PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd1,     17'd2},      PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd65534, 17'd65535},  PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd12345, 17'd12345},  PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd16384, 17'd49152},  PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd0,     17'd65537},  PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd43690, 17'd87381},  PREDICTED, '0},
      '{'{ace_pkg::OP_ENCODE, 16'd21845, 17'd43690},  PREDICTED, '0},
      '{'{ace_pkg::OP_FINISH, 16'd0,     17'd0},      PREDICTED, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) push_item(dir_tab[i].item, dir_tab[i].n_want, dir_tab[i].want);

    // hold the sender until the output side has caught up
    in_valid_i <= 1'b0;
    while (due_runs.size() != 0) @(posedge clk_i);

    // random messages: symbol intervals with some noise, each but maybe the last closed by a finish
    sent     = 0;
    quiet    = 1'b0;
    msg_left = $urandom_range(1, 12);
    while (sent < RAND_ITEMS) begin
      if (sent % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
      idle_en = !quiet && (sent < RAND_ITEMS - 30);
      if (msg_left == 0) begin
        it.op      = ace_pkg::OP_FINISH;
        it.cum_low = 16'($urandom);
        it.cum_top = 17'($urandom);
        msg_left   = $urandom_range(1, 12);
      end else if ($urandom_range(0, 7) == 0) begin
        it.op      = ace_pkg::OP_ENCODE;
        it.cum_low = 16'($urandom);
        it.cum_top = ($urandom_range(0, 3) == 0) ? {1'b0, it.cum_low} : 17'($urandom);
        msg_left--;
      end else begin
        it.op      = ace_pkg::OP_ENCODE;
        it.cum_low = 16'($urandom_range(0, 65535));
        // narrow symbols drive long renormalization runs
        if ($urandom_range(0, 9) < 3) width = $urandom_range(1, 16);
        else width = $urandom_range(1, 65536 - int'(it.cum_low));
        top = int'(it.cum_low) + width;
        if (top > 65536) top = 65536;
        it.cum_top = 17'(top);
        msg_left--;
      end
      push_item(it, PREDICTED, '0);
      sent++;
    end
    in_valid_i <= 1'b0;
    idle_en = 1'b0;

    drain = 0;
    while (due_runs.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (40) @(posedge clk_i);
    if (due_runs.size() != 0) begin
      $display("%0d expected runs never arrived", due_runs.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ace_pkg.sv
rtl/ace_mul.sv
rtl/ace_step.sv
rtl/arithmetic_coder_encoder.sv
test/testbench.sv
